### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed outside reset");

// Check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### rtl/core/mtpt_pkg.sv
// ----------------------------------------------------------------------------
// mtpt_pkg
// Types and constants of the multiturn encoder position tracker.
// ----------------------------------------------------------------------------
package mtpt_pkg;

  // Operation codes of a sample transfer
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_SET_REF = 1'b1;

  // Reported status codes
  localparam logic [1:0] STATUS_NOT_INIT = 2'd0;
  localparam logic [1:0] STATUS_VALID    = 2'd1;
  localparam logic [1:0] STATUS_FAULT    = 2'd2;

  // Reported fault causes
  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CAUSE_ALARM   = 2'd2;

  // Register indexes of the configuration port
  localparam int unsigned  REG_IDX_W = 3;
  localparam int unsigned  PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_POLE_PAIRS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_OFFSET  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TURN_THRESH   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REV_BITS      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MT_DISABLED   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ALM_DISABLED  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BATT_MASK     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MT_ALARM_MASK = 3'd7;

  // Acceleration saturation limits
  localparam logic [31:0] ACC_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ACC_MIN = 32'h8000_0000;

  // Tracker state, one-hot
  typedef enum logic [2:0] {
    TRK_INIT  = 3'b001,
    TRK_VALID = 3'b010,
    TRK_FAULT = 3'b100
  } track_state_t;

  typedef struct packed {
    logic [7:0]  pole_pairs;
    logic [15:0] phase_offset;
    logic [31:0] turn_start_threshold;
    logic [5:0]  revolution_bits;
    logic        multiturn_disabled;
    logic        alarms_disabled;
    logic [7:0]  battery_alarm_mask;
    logic [7:0]  multiturn_alarm_mask;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pole_pairs:           8'd1,
    phase_offset:         16'd0,
    turn_start_threshold: 32'hFFFF_FFFF,
    revolution_bits:      6'd0,
    multiturn_disabled:   1'b0,
    alarms_disabled:      1'b0,
    battery_alarm_mask:   8'h02,
    multiturn_alarm_mask: 8'h08
  };

  typedef struct packed {
    logic        op;
    logic        link_busy;
    logic        link_timeout;
    logic [7:0]  alarm_bits;
    logic [31:0] angle_word;
    logic [31:0] turn_word;
    logic        alarm_reset;
    logic        external_fault;
    logic        command_mode;
    logic [15:0] requested_elec_angle;
  } sample_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         fault_cause;
    logic signed [63:0] relative_position;
    logic signed [31:0] speed;
    logic signed [31:0] acceleration;
    logic [15:0]        elec_angle;
    logic               battery_warning;
    logic signed [31:0] turn_count;
  } result_t;

  typedef struct packed {
    logic [63:0]  initial_position;
    logic [63:0]  absolute_position;
    logic [31:0]  previous_speed;
    logic [15:0]  abs_elec_angle;
    logic [15:0]  elec_angle_delta;
    track_state_t track;
    logic         timeout_latched;
    logic         alarm_latched;
    logic         warning_latched;
  } track_t;

  localparam track_t TRACK_RESET = '{
    initial_position:  64'd0,
    absolute_position: 64'd0,
    previous_speed:    32'd0,
    abs_elec_angle:    16'd0,
    elec_angle_delta:  16'd0,
    track:             TRK_INIT,
    timeout_latched:   1'b0,
    alarm_latched:     1'b0,
    warning_latched:   1'b0
  };

endpackage

### rtl/core/mtpt_if.sv
// ----------------------------------------------------------------------------
// mtpt_if
// Valid/ready stream interfaces for samples and results.
// ----------------------------------------------------------------------------
interface mtpt_sample_if;
  logic              valid;
  logic              ready;
  mtpt_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mtpt_result_if;
  logic              valid;
  logic              ready;
  mtpt_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/mtpt_cfg.sv
// ----------------------------------------------------------------------------
// mtpt_cfg
// APB register bank holding the tracker configuration.
// ----------------------------------------------------------------------------
module mtpt_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mtpt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output mtpt_pkg::cfg_t               cfg
);
  import mtpt_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  // Write registers in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_POLE_PAIRS:    cfg.pole_pairs           <= pwdata[7:0];
        REG_PHASE_OFFSET:  cfg.phase_offset         <= pwdata[15:0];
        REG_TURN_THRESH:   cfg.turn_start_threshold <= pwdata;
        REG_REV_BITS:      cfg.revolution_bits      <= pwdata[5:0];
        REG_MT_DISABLED:   cfg.multiturn_disabled   <= pwdata[0];
        REG_ALM_DISABLED:  cfg.alarms_disabled      <= pwdata[0];
        REG_BATT_MASK:     cfg.battery_alarm_mask   <= pwdata[7:0];
        REG_MT_ALARM_MASK: cfg.multiturn_alarm_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_POLE_PAIRS:    prdata = {24'd0, cfg.pole_pairs};
      REG_PHASE_OFFSET:  prdata = {16'd0, cfg.phase_offset};
      REG_TURN_THRESH:   prdata = cfg.turn_start_threshold;
      REG_REV_BITS:      prdata = {26'd0, cfg.revolution_bits};
      REG_MT_DISABLED:   prdata = {31'd0, cfg.multiturn_disabled};
      REG_ALM_DISABLED:  prdata = {31'd0, cfg.alarms_disabled};
      REG_BATT_MASK:     prdata = {24'd0, cfg.battery_alarm_mask};
      REG_MT_ALARM_MASK: prdata = {24'd0, cfg.multiturn_alarm_mask};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/mtpt_step.sv
// ----------------------------------------------------------------------------
// mtpt_step
// Per-sample update: fault handling, turn counting, speed, acceleration and
// electrical angle, from the current tracker state to the next.
// ----------------------------------------------------------------------------
module mtpt_step (
  input  mtpt_pkg::cfg_t    cfg,
  input  mtpt_pkg::sample_t smp,
  input  mtpt_pkg::track_t  cur,
  output mtpt_pkg::track_t  nxt,
  output mtpt_pkg::result_t res
);
  import mtpt_pkg::*;

  logic [31:0] angle;
  logic [31:0] turns;
  logic [7:0]  alarm_eff;
  logic [31:0] rev_mask;
  logic [31:0] hi;
  logic [63:0] base_abs;
  logic [31:0] prev_angle;
  logic [31:0] speed_v;
  logic [31:0] diff;
  logic [23:0] prod;
  logic [31:0] spd_out;
  logic [31:0] acc_out;
  logic        done;

  // Mask of the turn-count bits
  always_comb begin
    if (cfg.revolution_bits == 6'd0) begin
      rev_mask = 32'd0;
    end else if (cfg.revolution_bits >= 6'd32) begin
      rev_mask = 32'hFFFF_FFFF;
    end else begin
      rev_mask = ~(32'hFFFF_FFFF << cfg.revolution_bits[4:0]);
    end
  end

  // State update
  always_comb begin
    nxt        = cur;
    spd_out    = 32'd0;
    acc_out    = 32'd0;
    done       = 1'b0;
    alarm_eff  = smp.alarm_bits;
    hi         = 32'd0;
    base_abs   = cur.absolute_position;
    prev_angle = 32'd0;
    speed_v    = 32'd0;
    diff       = 32'd0;
    prod       = 24'd0;
    angle      = smp.link_busy ? 32'd0 : smp.angle_word;
    turns      = smp.link_busy ? 32'd0 : smp.turn_word;

    if (smp.op == OP_SET_REF) begin
      // Move the electrical reference only
      nxt.elec_angle_delta = smp.requested_elec_angle - cur.abs_elec_angle
                             - cfg.phase_offset;
      spd_out = cur.previous_speed;
    end else begin
      priority if (smp.alarm_reset && (cur.timeout_latched || cur.alarm_latched ||
                                       cur.warning_latched || smp.external_fault)) begin
        // Clear latches and start over
        nxt.timeout_latched   = 1'b0;
        nxt.alarm_latched     = 1'b0;
        nxt.warning_latched   = 1'b0;
        nxt.initial_position  = 64'd0;
        nxt.absolute_position = 64'd0;
        nxt.previous_speed    = 32'd0;
        nxt.elec_angle_delta  = 16'd0;
        nxt.track             = TRK_INIT;
        done = 1'b1;
      end else if (smp.command_mode) begin
        nxt.track = TRK_INIT;
        done = 1'b1;
      end else if (cur.track == TRK_FAULT) begin
        done = 1'b1;
      end else if (smp.link_timeout || cur.timeout_latched) begin
        if (!cur.timeout_latched) begin
          nxt.track           = TRK_FAULT;
          nxt.timeout_latched = 1'b1;
        end
        done = 1'b1;
      end else begin
        // Encoder alarm byte: fatal bits latch, battery bits warn
        if (smp.alarm_bits != 8'd0 && !cfg.alarms_disabled) begin
          if (cfg.multiturn_disabled) begin
            alarm_eff = smp.alarm_bits &
                        ~(cfg.battery_alarm_mask | cfg.multiturn_alarm_mask);
          end
          if (!cur.alarm_latched) begin
            if ((alarm_eff & ~cfg.battery_alarm_mask) != 8'd0) begin
              nxt.track         = TRK_FAULT;
              nxt.alarm_latched = 1'b1;
              done = 1'b1;
            end else if ((alarm_eff & cfg.battery_alarm_mask) == cfg.battery_alarm_mask) begin
              nxt.warning_latched = 1'b1;
            end
          end
        end else begin
          nxt.warning_latched = 1'b0;
        end
      end

      if (!done) begin
        // Capture the start position on the first usable sample
        if (cur.track == TRK_INIT) begin
          if (!cfg.multiturn_disabled) begin
            hi = turns;
            if (rev_mask != 32'd0 && turns >= cfg.turn_start_threshold) begin
              hi = ~rev_mask | (turns & rev_mask);
            end
          end
          base_abs             = {hi, angle};
          nxt.initial_position = base_abs;
          nxt.track            = TRK_VALID;
        end

        prev_angle = base_abs[31:0];
        prod       = 24'(angle[31:16]) * 24'(cfg.pole_pairs);
        nxt.abs_elec_angle = prod[15:0];

        // Count a turn on a wrap between the top and bottom quadrants
        hi = base_abs[63:32];
        if (prev_angle[31:30] == 2'b11 && angle[31:30] == 2'b00) begin
          hi = hi + 32'd1;
        end else if (prev_angle[31:30] == 2'b00 && angle[31:30] == 2'b11) begin
          hi = hi - 32'd1;
        end
        nxt.absolute_position = {hi, angle};

        speed_v            = angle - prev_angle;
        nxt.previous_speed = speed_v;
        spd_out            = speed_v;

        // Acceleration: speed change times 4096, saturated
        diff = speed_v - cur.previous_speed;
        if (diff[31:19] == {13{diff[31]}}) begin
          acc_out = {diff[19:0], 12'd0};
        end else begin
          acc_out = diff[31] ? ACC_MIN : ACC_MAX;
        end
      end
    end
  end

  // Result from the updated state
  always_comb begin
    unique case (nxt.track)
      TRK_INIT:  res.status = STATUS_NOT_INIT;
      TRK_VALID: res.status = STATUS_VALID;
      TRK_FAULT: res.status = STATUS_FAULT;
      default:   res.status = STATUS_NOT_INIT;
    endcase
    res.fault_cause     = nxt.timeout_latched ? CAUSE_TIMEOUT :
                          (nxt.alarm_latched ? CAUSE_ALARM : CAUSE_NONE);
    res.battery_warning = nxt.warning_latched;
    if (nxt.track == TRK_VALID) begin
      res.relative_position = nxt.absolute_position - nxt.initial_position;
      res.speed             = spd_out;
      res.acceleration      = acc_out;
      res.elec_angle        = nxt.abs_elec_angle + nxt.elec_angle_delta + cfg.phase_offset;
      res.turn_count        = nxt.absolute_position[63:32];
    end else begin
      res.relative_position = 64'd0;
      res.speed             = 32'd0;
      res.acceleration      = 32'd0;
      res.elec_angle        = 16'd0;
      res.turn_count        = 32'd0;
    end
  end

endmodule

### rtl/core/multiturn_encoder_position_tracker_top.sv
// ----------------------------------------------------------------------------
// multiturn_encoder_position_tracker_top
// Multiturn absolute encoder position tracker with APB configuration.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  sample   | in  | valid/ready   | op, link status, alarms, angle, turns, ...
//  result   | out | valid/ready   | status, fault cause, position, speed, ...
//  apb      | in  | psel/penable  | 8 registers at byte address 4*index
//
//  A sample transfer loads the input register; processing the held sample
//  loads the result register and the tracker state together, so each result
//  passes through both registers.
//  One sample per cycle sustained while results are taken; the turn update
//  feeding the 64-bit position subtract sets the clock.
//  A stalled result holds the output register; the input register still takes
//  one more sample. Synchronous reset empties both registers and loads the
//  reset state and configuration.
// ----------------------------------------------------------------------------
module multiturn_encoder_position_tracker_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mtpt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  mtpt_sample_if.sink                  sample,
  mtpt_result_if.source                result
);
  import mtpt_pkg::*;

  cfg_t    cfg;
  sample_t in_data;
  logic    in_valid;
  track_t  trk;
  track_t  trk_next;
  result_t res_next;
  result_t out_data;
  logic    out_valid;
  logic    advance;

  mtpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtpt_step u_step (
    .cfg (cfg),
    .smp (in_data),
    .cur (trk),
    .nxt (trk_next),
    .res (res_next)
  );

  // Process the held sample when the result register is free
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_data <= sample.data;
    end
  end

  // Tracker state advances with each processed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      trk <= TRACK_RESET;
    end else if (advance) begin
      trk <= trk_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

### rtl/core/mtpt_checker.sv
// ----------------------------------------------------------------------------
// mtpt_checker
// Port-level checks of the position tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [1:0]  fault_cause,
  input logic [63:0] relative_position,
  input logic [31:0] speed,
  input logic [31:0] acceleration,
  input logic [15:0] elec_angle,
  input logic [31:0] turn_count
);
  import mtpt_pkg::*;

  // A result offered and not taken stays offered
  `ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)

  // No result in the cycle after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // Without valid positions every position field reads zero
  `ASSERT_RST(a_null_fields, clk, rst, out_valid && status != STATUS_VALID |-> relative_position == 64'd0 && speed == 32'd0 && acceleration == 32'd0 && elec_angle == 16'd0 && turn_count == 32'd0)

  // A fatal status always carries its latched cause
  `ASSERT_RST(a_fault_cause, clk, rst, out_valid && status == STATUS_FAULT |-> fault_cause == CAUSE_TIMEOUT || fault_cause == CAUSE_ALARM)

  // Input stalls only after a transfer has filled the input register
  `ASSERT_RST(a_in_ready, clk, rst, !in_ready |-> $past(in_valid && in_ready) || $past(!in_ready))

endmodule

bind multiturn_encoder_position_tracker_top mtpt_checker u_mtpt_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (sample.valid),
  .in_ready          (sample.ready),
  .out_valid         (result.valid),
  .out_ready         (result.ready),
  .status            (result.data.status),
  .fault_cause       (result.data.fault_cause),
  .relative_position (result.data.relative_position),
  .speed             (result.data.speed),
  .acceleration      (result.data.acceleration),
  .elec_angle        (result.data.elec_angle),
  .turn_count        (result.data.turn_count)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the multiturn encoder position tracker.
// Samples go in over the valid/ready sample channel with random gaps, and
// results come out against a receiver that stalls at random. A tracker model
// predicts every result, and each result transfer is checked field by field.
// The run starts with directed cases, then goes through several register
// settings with random motion, faults and recoveries.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtpt_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  mtpt_sample_if smp ();
  mtpt_result_if res ();

  multiturn_encoder_position_tracker_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (smp),
    .result  (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Tracker model: configuration and state
  cfg_t         cfg_model;
  logic [63:0]  trk_init_pos;
  logic [63:0]  trk_abs_pos;
  logic [31:0]  trk_prev_speed;
  logic [15:0]  trk_elec_abs;
  logic [15:0]  trk_elec_delta;
  logic [1:0]   trk_status;
  logic         trk_tmo;
  logic         trk_alm;
  logic         trk_warn;

  result_t      pending_results[$];

  // Traffic shaping shared between the test tasks and the receiver
  int unsigned  tx_gap_max = 0;
  int unsigned  rx_gap_max = 0;
  int unsigned  rx_hold    = 0;
  logic [31:0]  walk_angle = 32'd0;

  int unsigned  n_err      = 0;
  int unsigned  n_sent     = 0;
  int unsigned  n_checked  = 0;
  int unsigned  n_fault    = 0;
  int unsigned  n_settings = 0;
  int unsigned  quiet      = 0;

  // Speed change scaled by 4096, clamped to the int32 range
  function automatic logic [31:0] clamp_accel(input logic [31:0] diff);
    longint scaled;
    scaled = longint'($signed(diff)) * 64'sd4096;
    if (scaled > 64'sd2147483647) return ACC_MAX;
    if (scaled < -64'sd2147483648) return ACC_MIN;
    return 32'(scaled);
  endfunction

  // Build the reported result from the current tracker state
  function automatic result_t report_state(input logic [31:0] spd, input logic [31:0] acc);
    result_t r;
    r = '0;
    r.status          = trk_status;
    r.fault_cause     = trk_tmo ? CAUSE_TIMEOUT : (trk_alm ? CAUSE_ALARM : CAUSE_NONE);
    r.battery_warning = trk_warn;
    if (trk_status == STATUS_VALID) begin
      r.relative_position = trk_abs_pos - trk_init_pos;
      r.speed             = spd;
      r.acceleration      = acc;
      r.elec_angle        = trk_elec_abs + trk_elec_delta + cfg_model.phase_offset;
      r.turn_count        = trk_abs_pos[63:32];
    end
    return r;
  endfunction

  // Advance the tracker model by one accepted sample
  function automatic result_t track_sample(input sample_t s);
    logic [31:0] angle;
    logic [31:0] turns;
    logic [31:0] hi;
    logic [31:0] mask;
    logic [31:0] prev_angle;
    logic [31:0] prev_spd;
    logic [31:0] spd;
    logic [31:0] prod;
    logic [7:0]  alm;
    angle = s.angle_word;
    turns = s.turn_word;
    alm   = s.alarm_bits;

    // Reference update: only the electrical offset moves
    if (s.op == OP_SET_REF) begin
      trk_elec_delta = s.requested_elec_angle - trk_elec_abs - cfg_model.phase_offset;
      return report_state(trk_prev_speed, 32'd0);
    end

    // Alarm reset acts only when something is latched or the manager faults
    if (s.alarm_reset && (trk_tmo || trk_alm || trk_warn || s.external_fault)) begin
      trk_tmo        = 1'b0;
      trk_alm        = 1'b0;
      trk_warn       = 1'b0;
      trk_init_pos   = '0;
      trk_abs_pos    = '0;
      trk_prev_speed = '0;
      trk_elec_delta = '0;
      trk_status     = STATUS_NOT_INIT;
      return report_state(32'd0, 32'd0);
    end
    if (s.command_mode) begin
      trk_status = STATUS_NOT_INIT;
      return report_state(32'd0, 32'd0);
    end
    if (trk_status == STATUS_FAULT) return report_state(32'd0, 32'd0);

    if (s.link_busy) begin
      angle = '0;
      turns = '0;
    end

    if (s.link_timeout || trk_tmo) begin
      if (!trk_tmo) begin
        trk_status = STATUS_FAULT;
        trk_tmo    = 1'b1;
      end
      return report_state(32'd0, 32'd0);
    end

    // Encoder alarms: fatal outside the battery mask, warning inside it
    if (alm != 8'd0 && !cfg_model.alarms_disabled) begin
      if (cfg_model.multiturn_disabled)
        alm = alm & ~(cfg_model.battery_alarm_mask | cfg_model.multiturn_alarm_mask);
      if (!trk_alm) begin
        if ((alm & ~cfg_model.battery_alarm_mask) != 8'd0) begin
          trk_status = STATUS_FAULT;
          trk_alm    = 1'b1;
          return report_state(32'd0, 32'd0);
        end
        if ((alm & cfg_model.battery_alarm_mask) == cfg_model.battery_alarm_mask)
          trk_warn = 1'b1;
      end
    end else begin
      trk_warn = 1'b0;
    end

    // Capture the start position, sign-extending a high start turn count
    if (trk_status == STATUS_NOT_INIT) begin
      hi = '0;
      if (!cfg_model.multiturn_disabled) begin
        hi = turns;
        if (cfg_model.revolution_bits == 6'd0) mask = '0;
        else if (cfg_model.revolution_bits >= 6'd32) mask = '1;
        else mask = (32'd1 << cfg_model.revolution_bits) - 32'd1;
        if (mask != 32'd0 && hi >= cfg_model.turn_start_threshold)
          hi = ~mask | (hi & mask);
      end
      trk_init_pos = {hi, angle};
      trk_abs_pos  = trk_init_pos;
      trk_status   = STATUS_VALID;
    end

    prev_angle   = trk_abs_pos[31:0];
    prev_spd     = trk_prev_speed;
    prod         = (angle >> 16) * 32'(cfg_model.pole_pairs);
    trk_elec_abs = prod[15:0];

    // Count a turn on a wrap between the top and bottom quadrants
    hi = trk_abs_pos[63:32];
    if (prev_angle[31:30] == 2'b11 && angle[31:30] == 2'b00) hi = hi + 32'd1;
    else if (prev_angle[31:30] == 2'b00 && angle[31:30] == 2'b11) hi = hi - 32'd1;
    trk_abs_pos = {hi, angle};

    spd            = angle - prev_angle;
    trk_prev_speed = spd;
    return report_state(spd, clamp_accel(spd - prev_spd));
  endfunction

  // Offer one sample after a random gap and record its expected result
  task automatic push_sample(input sample_t s);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.data  <= s;
    do @(posedge clk); while (!smp.ready);
    pending_results.push_back(track_sample(s));
    n_sent++;
  endtask

  // Drop valid and hold until every expected result has been checked
  task automatic wait_idle();
    smp.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Write every register once the block has gone quiet
  task automatic apply_config(input cfg_t c);
    wait_idle();
    write_reg(REG_POLE_PAIRS,    {24'd0, c.pole_pairs});
    write_reg(REG_PHASE_OFFSET,  {16'd0, c.phase_offset});
    write_reg(REG_TURN_THRESH,   c.turn_start_threshold);
    write_reg(REG_REV_BITS,      {26'd0, c.revolution_bits});
    write_reg(REG_MT_DISABLED,   {31'd0, c.multiturn_disabled});
    write_reg(REG_ALM_DISABLED,  {31'd0, c.alarms_disabled});
    write_reg(REG_BATT_MASK,     {24'd0, c.battery_alarm_mask});
    write_reg(REG_MT_ALARM_MASK, {24'd0, c.multiturn_alarm_mask});
    psel      <= 1'b0;
    penable   <= 1'b0;
    cfg_model  = c;
    n_settings++;
  endtask

  function automatic sample_t clean_sample(input logic [31:0] angle, input logic [31:0] turns);
    sample_t s;
    s            = '0;
    s.op         = OP_SAMPLE;
    s.angle_word = angle;
    s.turn_word  = turns;
    return s;
  endfunction

  // Mostly smooth motion with random content; faults and noise now and then
  function automatic sample_t random_sample();
    sample_t     s;
    int unsigned pick;
    logic [31:0] delta_ang;
    logic        troubled;
    pick = $urandom_range(0, 99);
    if (pick < 50) delta_ang = $urandom_range(0, 32'h0000_FFFF);
    else if (pick < 85) delta_ang = $urandom_range(0, 32'h0FFF_FFFF);
    else if (pick < 95) delta_ang = $urandom_range(0, 32'h3FFF_FFFF);
    else delta_ang = $urandom();
    if ($urandom_range(0, 1)) delta_ang = -delta_ang;
    walk_angle = walk_angle + delta_ang;

    s = clean_sample(walk_angle, $urandom() >> $urandom_range(0, 31));
    s.requested_elec_angle = 16'($urandom());
    s.op           = ($urandom_range(0, 99) < 5) ? OP_SET_REF : OP_SAMPLE;
    s.link_busy    = ($urandom_range(0, 99) < 3);
    s.link_timeout = ($urandom_range(0, 99) < 2);
    s.command_mode = ($urandom_range(0, 99) < 3);

    // Recover quickly once something is latched
    troubled = (trk_status == STATUS_FAULT) || trk_tmo || trk_alm || trk_warn;
    s.alarm_reset    = ($urandom_range(0, 99) < (troubled ? 35 : 4));
    s.external_fault = 1'($urandom_range(0, 1));

    pick = $urandom_range(0, 99);
    if (pick < 80) s.alarm_bits = 8'h00;
    else if (pick < 88) s.alarm_bits = cfg_model.battery_alarm_mask;
    else if (pick < 93) s.alarm_bits = cfg_model.multiturn_alarm_mask;
    else s.alarm_bits = 8'($urandom());
    return s;
  endfunction

  // Directed walk through wraps, extremes, references, alarms and recoveries
  task automatic test_directed_cases();
    sample_t s;
    tx_gap_max = 2;
    rx_gap_max = 2;
    push_sample(clean_sample(32'hC000_0000, 32'd5));
    push_sample(clean_sample(32'h1000_0000, 32'd5));
    push_sample(clean_sample(32'hF000_0000, 32'd5));
    push_sample(clean_sample(32'h7FFF_FFFF, 32'd5));
    push_sample(clean_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_sample(clean_sample(32'h0000_0000, 32'h0000_0000));
    s = clean_sample(32'h1234_5678, 32'd0);
    s.op = OP_SET_REF;
    s.requested_elec_angle = 16'hFFFF;
    push_sample(s);
    s = clean_sample(32'h8000_0000, 32'd9);
    s.link_busy = 1'b1;
    push_sample(s);
    s = clean_sample(32'h0100_0000, 32'd0);
    s.alarm_bits = 8'h02;
    push_sample(s);
    push_sample(clean_sample(32'h0200_0000, 32'd0));
    s = clean_sample(32'h0300_0000, 32'd0);
    s.alarm_bits = 8'h02;
    push_sample(s);
    s = clean_sample(32'h0400_0000, 32'd0);
    s.alarm_reset = 1'b1;
    push_sample(s);
    s = clean_sample(32'h0500_0000, 32'd0);
    s.command_mode = 1'b1;
    push_sample(s);
    push_sample(clean_sample(32'h4000_0000, 32'd3));
    s = clean_sample(32'h4100_0000, 32'd3);
    s.alarm_bits = 8'hFF;
    push_sample(s);
    push_sample(clean_sample(32'h4200_0000, 32'd3));
    s = clean_sample(32'h4300_0000, 32'd3);
    s.alarm_reset = 1'b1;
    push_sample(s);
    s = clean_sample(32'h4400_0000, 32'd3);
    s.link_timeout = 1'b1;
    push_sample(s);
    s = clean_sample(32'h4500_0000, 32'd3);
    s.alarm_reset    = 1'b1;
    s.external_fault = 1'b1;
    push_sample(s);
    s = clean_sample(32'h4600_0000, 32'd3);
    s.alarm_reset    = 1'b1;
    s.external_fault = 1'b1;
    push_sample(s);
    s = clean_sample(32'h4700_0000, 32'd3);
    s.alarm_reset = 1'b1;
    push_sample(s);
  endtask

  // Start turn counts on either side of the threshold with 12 turn bits
  task automatic test_turn_extension();
    cfg_t    c;
    sample_t s;
    c = cfg_model;
    c.revolution_bits      = 6'd12;
    c.turn_start_threshold = 32'h0000_0800;
    apply_config(c);
    s = clean_sample(32'd0, 32'd0);
    s.command_mode = 1'b1;
    push_sample(s);
    push_sample(clean_sample(32'h2000_0000, 32'h0000_0FFF));
    push_sample(s);
    push_sample(clean_sample(32'h2000_0000, 32'h0000_07FF));
  endtask

  // Random traffic under one register setting, with a drain halfway through
  task automatic test_random_traffic(input cfg_t c, input int unsigned n);
    apply_config(c);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 70 == 0) begin
        tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (i == n / 2) wait_idle();
      push_sample(random_sample());
    end
  endtask

  // Stall the receiver long enough for the block to back up its input
  task automatic test_output_backpressure();
    tx_gap_max = 0;
    rx_hold    = 80;
    repeat (20) push_sample(random_sample());
    wait_idle();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_err++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Result receiver: random stalls per transfer, plus a long hold on request
  initial begin
    int unsigned stall;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (rx_hold > 0) begin
        stall   = stall + rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        n_err++;
        $error("result transfer with no sample outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(res.data.status));
        check_field("fault_cause", 64'(want.fault_cause), 64'(res.data.fault_cause));
        check_field("relative_position", want.relative_position,
                    res.data.relative_position);
        check_field("speed", 64'(want.speed), 64'(res.data.speed));
        check_field("acceleration", 64'(want.acceleration), 64'(res.data.acceleration));
        check_field("elec_angle", 64'(want.elec_angle), 64'(res.data.elec_angle));
        check_field("battery_warning", 64'(want.battery_warning),
                    64'(res.data.battery_warning));
        check_field("turn_count", 64'(want.turn_count), 64'(res.data.turn_count));
        n_checked++;
        if (want.status == STATUS_FAULT) n_fault++;
      end
    end
  end

  // Give up when neither channel has moved for too long
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    cfg_t c;
    rst       <= 1'b1;
    smp.valid <= 1'b0;
    smp.data  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    cfg_model      = CFG_RESET;
    trk_init_pos   = '0;
    trk_abs_pos    = '0;
    trk_prev_speed = '0;
    trk_elec_abs   = '0;
    trk_elec_delta = '0;
    trk_status     = STATUS_NOT_INIT;
    trk_tmo        = 1'b0;
    trk_alm        = 1'b0;
    trk_warn       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_turn_extension();
    test_random_traffic(CFG_RESET, 220);
    test_output_backpressure();

    // Upper extremes: everything masked off the multiturn side
    c = '{pole_pairs: 8'hFF, phase_offset: 16'hFFFF, turn_start_threshold: 32'd0,
          revolution_bits: 6'd63, multiturn_disabled: 1'b1, alarms_disabled: 1'b0,
          battery_alarm_mask: 8'hFF, multiturn_alarm_mask: 8'hFF};
    test_random_traffic(c, 220);

    // Lower extremes with alarms ignored
    c = '{pole_pairs: 8'd0, phase_offset: 16'd0, turn_start_threshold: 32'hFFFF_FFFF,
          revolution_bits: 6'd32, multiturn_disabled: 1'b0, alarms_disabled: 1'b1,
          battery_alarm_mask: 8'h00, multiturn_alarm_mask: 8'h00};
    test_random_traffic(c, 200);

    c = '{pole_pairs: 8'd7, phase_offset: 16'h1234, turn_start_threshold: 32'h0000_8000,
          revolution_bits: 6'd16, multiturn_disabled: 1'b0, alarms_disabled: 1'b0,
          battery_alarm_mask: 8'h03, multiturn_alarm_mask: 8'h30};
    test_random_traffic(c, 220);

    c.pole_pairs           = 8'($urandom());
    c.phase_offset         = 16'($urandom());
    c.turn_start_threshold = $urandom() >> $urandom_range(0, 31);
    c.revolution_bits      = 6'($urandom_range(1, 40));
    c.multiturn_disabled   = 1'($urandom_range(0, 1));
    c.alarms_disabled      = 1'b0;
    c.battery_alarm_mask   = 8'($urandom());
    c.multiturn_alarm_mask = 8'($urandom());
    test_random_traffic(c, 220);

    wait_idle();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      n_err++;
      $error("%0d expected results never arrived", pending_results.size());
    end

    $display("Sent %0d samples across %0d register settings, with stalls and drains.",
             n_sent, n_settings);
    $display("Checked %0d results, %0d of them in the fatal state; %0d mismatches.",
             n_checked, n_fault, n_err);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
